// ===== hw/rtl/mcds_pkg.sv =====
// ----------------------------------------------------------------------------
// mcds_pkg
// shared constants, types and helpers of the mask composite with drop shadow
// ----------------------------------------------------------------------------
package mcds_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int SHADOW_LENGTH = 3;
    localparam int RING_ROWS     = SHADOW_LENGTH + 1;
    localparam int MAX_HEIGHT    = 4096;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int BANK_W  = $clog2(RING_ROWS);
    localparam int ROW_W   = 12;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int WCMP_W  = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;
    localparam int RGB_W   = 24;
    localparam int FLAG_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(768);

    localparam int                FLAG_EMPTY_BIT = 0;
    localparam logic [FLAG_W-1:0] FLAG_DIRT      = 8'h02;
    localparam logic [FLAG_W-1:0] FLAG_ROCK      = 8'h04;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SHADOWS      = 2'd2
    } t_cfg_idx;

    // row store access for one accepted pixel
    typedef struct packed {
        logic              en;
        logic [BANK_W-1:0] bank;
        logic [COL_W-1:0]  x;
        logic              wbit;
    } t_store_req;

    // pixel waiting for its row store lookups
    typedef struct packed {
        logic [RGB_W-1:0]         back_rgb;
        logic [RGB_W-1:0]         front_rgb;
        logic [FLAG_W-1:0]        pixel_flag;
        logic                     shadows;
        logic                     last;
        logic [BANK_W-1:0]        bank;
        logic [SHADOW_LENGTH-1:0] in_range;
    } t_pix_item;

    // bank of the row that lies k rows above the row in bank cur
    function automatic logic [BANK_W-1:0] bank_back(input logic [BANK_W-1:0] cur,
                                                   input logic [BANK_W-1:0] k);
        logic [BANK_W:0] t;
        t = {1'b0, cur} + (BANK_W+1)'(RING_ROWS) - {1'b0, k};
        if (t >= (BANK_W+1)'(RING_ROWS)) begin
            t = t - (BANK_W+1)'(RING_ROWS);
        end
        return t[BANK_W-1:0];
    endfunction

    function automatic logic [7:0] darken_ch(input logic [7:0] c);
        logic [9:0] t;
        t = {2'b00, c} + {1'b0, c, 1'b0};
        return t[9:2];
    endfunction

    function automatic logic [RGB_W-1:0] darken(input logic [RGB_W-1:0] rgb);
        return {darken_ch(rgb[23:16]), darken_ch(rgb[15:8]), darken_ch(rgb[7:0])};
    endfunction

endpackage

// ===== hw/rtl/mcds_in_if.sv =====
// ----------------------------------------------------------------------------
// mcds_in_if
// input pixel channel: background, foreground and flag byte
// ----------------------------------------------------------------------------
interface mcds_in_if import mcds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RGB_W-1:0]  back_rgb;
    logic [RGB_W-1:0]  front_rgb;
    logic [FLAG_W-1:0] pixel_flag;

    modport source (output valid, output back_rgb, output front_rgb,
                    output pixel_flag, input ready);
    modport sink   (input valid, input back_rgb, input front_rgb,
                    input pixel_flag, output ready);
endinterface

// ===== hw/rtl/mcds_out_if.sv =====
// ----------------------------------------------------------------------------
// mcds_out_if
// output pixel channel: final colour and end of frame marker
// ----------------------------------------------------------------------------
interface mcds_out_if import mcds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] pixel_rgb;
    logic             frame_last;

    modport source (output valid, output pixel_rgb, output frame_last, input ready);
    modport sink   (input valid, input pixel_rgb, input frame_last, output ready);
endinterface

// ===== hw/rtl/mask_composite_drop_shadow_top.sv =====
// ----------------------------------------------------------------------------
// mask_composite_drop_shadow_top
// raster pixel composite by material flag with an optional diagonal shadow
// ----------------------------------------------------------------------------
// Takes one pixel per clock while results are taken and gives one result per
// pixel via the lookup and output registers. The rate is set by the row store:
// each row kept for the shadow has its own one-port bank, so the current row
// writes one bank while the diagonal reads one bit in each of the others in the
// same cycle. The store needs no clearing pass after reset; rows are written
// before the diagonal reaches them within a frame. Users must write frame size
// and shadow enable while no pixel is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module mask_composite_drop_shadow_top import mcds_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcds_in_if.sink               i_pix,
    mcds_out_if.source            o_pix
);

    logic [FW_W-1:0]   r_fw;
    logic [FH_W-1:0]   r_fh;
    logic              r_shadows;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [BANK_W-1:0] r_bank;

    logic [WCMP_W-1:0]    w_eff;
    logic [FH_W-1:0]      h_eff;
    logic                 take;
    logic                 ready;
    logic                 row_end;
    logic                 frame_end;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;
    logic [BANK_W-1:0]    n_bank;
    t_store_req           req;
    t_pix_item            item;
    logic [RING_ROWS-1:0] bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= FW_RESET;
            r_fh      <= FH_RESET;
            r_shadows <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_fw      <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_fh      <= i_cfg_data[FH_W-1:0];
                CFG_SHADOWS:      r_shadows <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_fw == '0) begin
            w_eff = WCMP_W'(1);
        end else if (WCMP_W'(r_fw) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = WCMP_W'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = FH_W'(1);
        end else if (r_fh > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_fh;
        end
    end

    assign take      = i_pix.valid && ready;
    assign row_end   = (WCMP_W'(r_col) + WCMP_W'(1)) >= w_eff;
    assign frame_end = row_end && ((FH_W'(r_row) + FH_W'(1)) >= h_eff);

    always_comb begin
        n_col  = r_col + COL_W'(1);
        n_row  = r_row;
        n_bank = r_bank;
        if (row_end) begin
            n_col = '0;
            if (frame_end) begin
                n_row  = '0;
                n_bank = '0;
            end else begin
                n_row  = r_row + ROW_W'(1);
                n_bank = (r_bank == BANK_W'(RING_ROWS - 1)) ? '0 : r_bank + BANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
        end else if (take) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bank <= n_bank;
        end
    end

    assign req.en   = take;
    assign req.bank = r_bank;
    assign req.x    = r_col;
    assign req.wbit = i_pix.pixel_flag[FLAG_EMPTY_BIT];

    always_comb begin
        item.back_rgb   = i_pix.back_rgb;
        item.front_rgb  = i_pix.front_rgb;
        item.pixel_flag = i_pix.pixel_flag;
        item.shadows    = r_shadows;
        item.last       = frame_end;
        item.bank       = r_bank;
        for (int k = 1; k <= SHADOW_LENGTH; k++) begin
            item.in_range[k-1] = (32'(r_col) >= 32'(k)) && (32'(r_row) >= 32'(k));
        end
    end

    mcds_row_store u_row_store (
        .i_clk  (i_clk),
        .i_req  (req),
        .o_bits (bits)
    );

    mcds_pixel_stage u_pixel_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (item),
        .i_bits  (bits),
        .o_ready (ready),
        .o_pix   (o_pix)
    );

    assign i_pix.ready = ready;

endmodule

// ===== hw/rtl/mcds_row_store.sv =====
// ----------------------------------------------------------------------------
// mcds_row_store
// empty bits of the current row and the rows above it, one bank per row,
// each bank written by the current row or read once on the up-left diagonal
// ----------------------------------------------------------------------------
module mcds_row_store import mcds_pkg::*; (
    input  logic                 i_clk,
    input  t_store_req           i_req,
    output logic [RING_ROWS-1:0] o_bits
);

    for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
        logic              r_mem [MAX_WIDTH];
        logic [BANK_W-1:0] back_k;
        logic [COL_W-1:0]  raddr;

        assign back_k = bank_back(i_req.bank, BANK_W'(b));
        assign raddr  = i_req.x - COL_W'(back_k);

        always_ff @(posedge i_clk) begin
            if (i_req.en) begin
                o_bits[b] <= r_mem[raddr];
                if (i_req.bank == BANK_W'(b)) begin
                    r_mem[i_req.x] <= i_req.wbit;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mcds_pixel_stage.sv =====
// ----------------------------------------------------------------------------
// mcds_pixel_stage
// lookup stage and output register: shadow decision, colour select, darkening
// ----------------------------------------------------------------------------
module mcds_pixel_stage import mcds_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  t_pix_item            i_item,
    input  logic [RING_ROWS-1:0] i_bits,
    output logic                 o_ready,
    mcds_out_if.source           o_pix
);

    logic             r_s1_vld;
    t_pix_item        r_s1;
    logic             r_out_vld;
    logic [RGB_W-1:0] r_out_rgb;
    logic             r_out_last;

    logic             out_adv;
    logic             s1_adv;
    logic             hit;
    logic             walk;
    logic [RGB_W-1:0] sel_rgb;
    logic [RGB_W-1:0] n_out_rgb;

    assign out_adv = !r_out_vld || o_pix.ready;
    assign s1_adv  = r_s1_vld && out_adv;
    assign o_ready = !r_s1_vld || out_adv;

    // first clear empty bit on the diagonal within reach
    always_comb begin
        walk = 1'b1;
        hit  = 1'b0;
        for (int k = 1; k <= SHADOW_LENGTH; k++) begin
            if (walk) begin
                if (!r_s1.in_range[k-1]) begin
                    walk = 1'b0;
                end else if (!i_bits[bank_back(r_s1.bank, BANK_W'(k))]) begin
                    hit  = 1'b1;
                    walk = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (r_s1.pixel_flag == FLAG_DIRT || r_s1.pixel_flag == FLAG_ROCK) begin
            sel_rgb = r_s1.front_rgb;
        end else begin
            sel_rgb = r_s1.back_rgb;
        end
        if (r_s1.shadows && r_s1.pixel_flag[FLAG_EMPTY_BIT] && hit) begin
            n_out_rgb = darken(sel_rgb);
        end else begin
            n_out_rgb = sel_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_take) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= i_item;
        end
        if (s1_adv) begin
            r_out_rgb  <= n_out_rgb;
            r_out_last <= r_s1.last;
        end
    end

    assign o_pix.valid      = r_out_vld;
    assign o_pix.pixel_rgb  = r_out_rgb;
    assign o_pix.frame_last = r_out_last;

endmodule

// ===== hw/rtl/mcds_checker.sv =====
// ----------------------------------------------------------------------------
// mcds_checker
// port level checks of the pixel pipeline occupancy and output handshake
// ----------------------------------------------------------------------------
module mcds_checker import mcds_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [RGB_W-1:0] i_out_pixel_rgb,
    input logic             i_out_frame_last
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!in_acc && out_acc) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_no_invented_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_cnt != 2'd0)
        else $error("result without a pending request");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> i_in_ready)
        else $error("empty pipeline not ready");

    a_full_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && in_acc) |-> out_acc)
        else $error("request taken into a full pipeline");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_pixel_rgb) && $stable(i_out_frame_last)))
        else $error("stalled result changed");

endmodule

bind mask_composite_drop_shadow_top mcds_checker u_mcds_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_pix.valid),
    .i_in_ready       (i_pix.ready),
    .i_out_valid      (o_pix.valid),
    .i_out_ready      (o_pix.ready),
    .i_out_pixel_rgb  (o_pix.pixel_rgb),
    .i_out_frame_last (o_pix.frame_last)
);

// ===== tb/sv/mask_composite_drop_shadow_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_composite_drop_shadow_top_test
// self-checking bench for the mask composite with diagonal drop shadow.
// pixels go in through the request channel with random gaps. Results are
// taken with random back-pressure. Each result is compared with a shadow
// model that keeps its own row store, counters and register copy. Frame
// sizes and the shadow enable change between bursts, only when the block
// is idle. Widening always starts on a fresh frame. The model is driven
// there by a one-pixel frame when needed.
// ----------------------------------------------------------------------------
module mask_composite_drop_shadow_top_test;
    import mcds_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [FLAG_W-1:0] FLAG_NONE      = 8'h00;
    localparam logic [FLAG_W-1:0] FLAG_EMPTY     = 8'h01;
    localparam logic [FLAG_W-1:0] FLAG_ODD_EMPTY = 8'h03;
    localparam logic [FLAG_W-1:0] FLAG_ODD_CLEAR = 8'h80;
    localparam logic [FLAG_W-1:0] FLAG_ALL       = 8'hFF;

    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic             last;
    } t_shaded_pixel;

    class pixel_tracker;
        bit              empty_rows [RING_ROWS][MAX_WIDTH];
        t_shaded_pixel   expected_q [$];
        int unsigned     col_cnt;
        int unsigned     row_cnt;
        logic [FW_W-1:0] width_reg;
        logic [FH_W-1:0] height_reg;
        logic            shadow_en;
        int unsigned     errors;

        function new();
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            shadow_en  = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
                CFG_SHADOWS:      shadow_en  = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned width_for(logic [FW_W-1:0] v);
            int unsigned w;
            w = 32'(v);
            if (w == 0) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned eff_width();
            return width_for(width_reg);
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = 32'(height_reg);
            if (h == 0) h = 1;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            return h;
        endfunction

        function bit at_frame_start();
            return (col_cnt == 0) && (row_cnt == 0);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function logic [7:0] dim(logic [7:0] c);
            int unsigned t;
            t = 32'(c) * 3;
            return 8'(t / 4);
        endfunction

        // walk up-left until a filled pixel, the frame edge or the shadow length
        function bit diagonal_hit(int unsigned x, int unsigned y);
            int unsigned k;
            for (k = 1; k <= SHADOW_LENGTH; k++) begin
                if (x < k || y < k) return 1'b0;
                if (!empty_rows[BANK_W'((y - k) % RING_ROWS)][COL_W'((x - k) % MAX_WIDTH)])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_pixel(logic [RGB_W-1:0] back, logic [RGB_W-1:0] front,
                                 logic [FLAG_W-1:0] flag);
            t_shaded_pixel p;
            int unsigned   w;
            int unsigned   h;
            int unsigned   x;
            int unsigned   y;
            bit            empty;
            bit            row_end;
            w     = eff_width();
            h     = eff_height();
            x     = col_cnt % MAX_WIDTH;
            y     = row_cnt;
            empty = flag[FLAG_EMPTY_BIT];
            p.rgb = (flag == FLAG_DIRT || flag == FLAG_ROCK) ? front : back;
            if (shadow_en && empty && diagonal_hit(x, y)) begin
                p.rgb = {dim(p.rgb[23:16]), dim(p.rgb[15:8]), dim(p.rgb[7:0])};
            end
            empty_rows[BANK_W'(y % RING_ROWS)][COL_W'(x)] = empty;
            row_end = (x + 1 >= w);
            p.last  = row_end && (y + 1 >= h);
            if (row_end) begin
                col_cnt = 0;
                row_cnt = (y + 1 >= h) ? 0 : y + 1;
            end else begin
                col_cnt = x + 1;
            end
            expected_q.push_back(p);
        endfunction

        function void match_pixel(logic [RGB_W-1:0] rgb, logic last);
            t_shaded_pixel p;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, pixel_rgb %h frame_last %b",
                         $time, rgb, last);
                errors++;
                return;
            end
            p = expected_q.pop_front();
            if (rgb !== p.rgb) begin
                $display("%0t: pixel_rgb expected %h actual %h", $time, p.rgb, rgb);
                errors++;
            end
            if (last !== p.last) begin
                $display("%0t: frame_last expected %b actual %b", $time, p.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit                    idle_on;

    mcds_in_if  pix_in ();
    mcds_out_if pix_out ();

    pixel_tracker tracker = new();

    mask_composite_drop_shadow_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [RGB_W-1:0] rand_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return RGB_W'($urandom);
        endcase
    endfunction

    function automatic logic [FLAG_W-1:0] rand_flag();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 8) return FLAG_EMPTY;
        if (r < 11) return FLAG_DIRT;
        if (r < 14) return FLAG_ROCK;
        if (r < 16) return FLAG_NONE;
        return FLAG_W'($urandom);
    endfunction

    // caller lowers the write enable once the last register is written
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic send_pixel(logic [RGB_W-1:0] back, logic [RGB_W-1:0] front,
                              logic [FLAG_W-1:0] flag);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.back_rgb   <= back;
        pix_in.front_rgb  <= front;
        pix_in.pixel_flag <= flag;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        tracker.take_pixel(back, front, flag);
    endtask

    task automatic wait_drain();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_pixels(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_pixel(rand_color(), rand_color(), rand_flag());
        end
        pix_in.valid <= 1'b0;
        wait_drain();
    endtask

    // a wider row needs a fresh frame, else the diagonal reads unwritten bits
    task automatic apply_setting(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data,
                                 logic [CFG_DATA_W-1:0] sh_data, bit from_start);
        if (!tracker.at_frame_start() &&
            (from_start || tracker.width_for(w_data[FW_W-1:0]) > tracker.eff_width())) begin
            write_cfg(CFG_FRAME_WIDTH, CFG_DATA_W'(1));
            write_cfg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
            i_cfg_we <= 1'b0;
            run_pixels(1);
        end
        if ($urandom_range(0, 7) == 0) write_cfg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_cfg(CFG_FRAME_WIDTH, w_data);
        write_cfg(CFG_FRAME_HEIGHT, h_data);
        write_cfg(CFG_SHADOWS, sh_data);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned stall;
        stall         = 0;
        pix_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out.valid && pix_out.ready) begin
                tracker.match_pixel(pix_out.pixel_rgb, pix_out.frame_last);
            end
            if (stall > 0) begin
                stall--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
            end
            pix_out.ready <= (stall == 0);
        end
    end

    initial begin
        int unsigned           random_items;
        int unsigned           n;
        logic [FLAG_W-1:0]     flag;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        logic [CFG_DATA_W-1:0] sh_data;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_FRAME_WIDTH;
        i_cfg_data        = '0;
        pix_in.valid      = 1'b0;
        pix_in.back_rgb   = '0;
        pix_in.front_rgb  = '0;
        pix_in.pixel_flag = '0;
        idle_on           = 1'b1;
        random_items      = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, every flag class, colour extremes
        send_pixel(24'hFFFFFF, 24'h000000, FLAG_NONE);
        send_pixel(24'h000000, 24'hFFFFFF, FLAG_DIRT);
        send_pixel(24'hFFFFFF, 24'h000000, FLAG_ROCK);
        send_pixel(24'h000000, 24'hFFFFFF, FLAG_ALL);
        send_pixel(24'hFFFFFF, 24'h000000, FLAG_EMPTY);
        pix_in.valid <= 1'b0;
        wait_drain();

        // small frame: shadow at one and three steps, walk off the edge
        apply_setting(CFG_DATA_W'(5), CFG_DATA_W'(4), CFG_DATA_W'(1), 1'b1);
        for (int unsigned y = 0; y < 4; y++) begin
            for (int unsigned x = 0; x < 5; x++) begin
                if (x == 0 && y == 0) flag = FLAG_ROCK;
                else if (x == 4 && y == 2) flag = FLAG_ODD_CLEAR;
                else if (x == 1 && y == 2) flag = FLAG_ODD_EMPTY;
                else flag = FLAG_EMPTY;
                send_pixel(24'hFFFFFF, rand_color(), flag);
            end
        end
        pix_in.valid <= 1'b0;
        wait_drain();

        while (random_items < 500) begin
            idle_on = (random_items < 420) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: w_data = '0;
                1: w_data = CFG_DATA_W'(MAX_WIDTH);
                2: w_data = 13'h07FF;
                3: w_data = CFG_DATA_W'($urandom_range(MAX_WIDTH + 1, 2047));
                4: w_data = CFG_DATA_W'($urandom_range(17, MAX_WIDTH - 1));
                default: w_data = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            w_data[CFG_DATA_W-1:FW_W] = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: h_data = '0;
                1: h_data = CFG_DATA_W'(MAX_HEIGHT);
                2: h_data = 13'h1FFF;
                3: h_data = CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
                4: h_data = CFG_DATA_W'($urandom_range(9, MAX_HEIGHT - 1));
                default: h_data = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            sh_data    = CFG_DATA_W'($urandom);
            sh_data[0] = ($urandom_range(0, 3) != 0);
            apply_setting(w_data, h_data, sh_data, 1'b0);
            if (tracker.eff_width() <= 16) n = $urandom_range(20, 60);
            else n = $urandom_range(10, 40);
            run_pixels(n);
            random_items += n;
        end

        wait_drain();
        if (tracker.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mcds_pkg.sv
hw/rtl/mcds_in_if.sv
hw/rtl/mcds_out_if.sv
hw/rtl/mcds_row_store.sv
hw/rtl/mcds_pixel_stage.sv
hw/rtl/mask_composite_drop_shadow_top.sv
hw/rtl/mcds_checker.sv
tb/sv/mask_composite_drop_shadow_top_test.sv
